### rtl/i2c_master_single_byte_sequencer_macros.svh
// Assertion macros for the single-byte I2C master sequencer.
// Used by the top level only; no other dependencies.
`ifndef I2C_MASTER_SINGLE_BYTE_SEQUENCER_MACROS_SVH
`define I2C_MASTER_SINGLE_BYTE_SEQUENCER_MACROS_SVH

// Same-cycle implication, disabled in reset
`define ISQ_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled in reset
`define ISQ_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

### rtl/isq_pkg.sv
// Types and codes for the single-byte I2C master sequencer.
// No dependencies; imported by isq_step and the top level.
package isq_pkg;

  typedef enum logic [1:0] {
    FUNC_WRITE = 2'd0,
    FUNC_READ  = 2'd1,
    FUNC_EVENT = 2'd2
  } func_t;

  typedef enum logic [2:0] {
    CMD_NONE  = 3'd0,
    CMD_START = 3'd1,
    CMD_TX    = 3'd2,
    CMD_RCEN  = 3'd3,
    CMD_NACK  = 3'd4,
    CMD_STOP  = 3'd5,
    CMD_DONE  = 3'd6
  } cmd_t;

  typedef enum logic [2:0] {
    PH_RESET   = 3'd0,
    PH_ADDR_WR = 3'd1,
    PH_ADDR_RD = 3'd2,
    PH_DATA_TX = 3'd3,
    PH_RX_EN   = 3'd4,
    PH_RX      = 3'd5,
    PH_STOP    = 3'd6,
    PH_FINISH  = 3'd7
  } phase_t;

  typedef struct packed {
    logic [1:0] func;
    logic [6:0] target_addr;
    logic [7:0] write_byte;
    logic       nack_seen;
    logic [7:0] rx_byte;
  } item_t;

  typedef struct packed {
    phase_t     phase;
    logic [6:0] held_addr;
    logic [7:0] held_write_byte;
  } seq_state_t;

  typedef struct packed {
    cmd_t       command;
    logic [7:0] tx_byte;
    logic [7:0] read_data;
    logic       read_valid;
  } result_t;

endpackage

### rtl/i2c_master_single_byte_sequencer.sv
// Single-byte I2C master sequencer, top level: input register, step logic,
// result register and phase state. Depends on isq_pkg, isq_step and the macros header.
//
// Drives a byte-level I2C master engine through one write or one read
// transaction. A start word (func 0 write, 1 read) latches the target address
// (and the data byte for a write) and returns START; each completion event word
// (func 2) then returns the next engine command: address byte with R/W bit,
// data byte or receive enable, NACK with the received byte on read_data /
// read_valid, STOP, and finally "transaction finished". A NACK after address or
// data goes straight to STOP. A start word always abandons any transaction in
// progress. Every accepted word produces exactly one result word. Throughput is
// one word per cycle while the result side keeps taking words; a held-off result
// stalls the input register and then the input. An accepted word passes through
// the input register and then the result register before its result is offered,
// and a held-off result can hold it in the input register between the two.
// The only feedback path is the phase/held-operand register updated
// by the step logic as a word moves from the input register to the result register.
`include "i2c_master_single_byte_sequencer_macros.svh"

module i2c_master_single_byte_sequencer (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [1:0] func,
  input  logic [6:0] target_addr,
  input  logic [7:0] write_byte,
  input  logic       nack_seen,
  input  logic [7:0] rx_byte,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [2:0] command,
  output logic [7:0] tx_byte,
  output logic [7:0] read_data,
  output logic       read_valid
);
  import isq_pkg::*;

  // input register
  logic       in_reg_valid;
  item_t      in_reg;

  // result register
  logic       res_valid;
  result_t    res;

  // sequencer state
  seq_state_t state;
  seq_state_t state_next;
  result_t    step_result;

  logic       advance;

  // Advance a word when the result register is empty or being drained.
  assign advance  = in_reg_valid && (!res_valid || out_ready);
  // Take a new word whenever the input register is empty or moving on.
  assign in_ready = !in_reg_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_reg_valid <= 1'b0;
    end else if (in_ready) begin
      in_reg_valid <= in_valid;
    end
  end

  // Payload: load on acceptance, hold otherwise
  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      in_reg <= '{func: func, target_addr: target_addr, write_byte: write_byte,
                  nack_seen: nack_seen, rx_byte: rx_byte};
    end
  end

  isq_step u_step (
    .item       (in_reg),
    .state      (state),
    .state_next (state_next),
    .result     (step_result)
  );

  // Commit the state only when the word actually moves into the result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= '{phase: PH_RESET, held_addr: 7'd0, held_write_byte: 8'd0};
    end else if (advance) begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (!res_valid || out_ready) begin
      res_valid <= in_reg_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      res <= step_result;
    end
  end

  assign out_valid  = res_valid;
  assign command    = res.command;
  assign tx_byte    = res.tx_byte;
  assign read_data  = res.read_data;
  assign read_valid = res.read_valid;

  // A received byte only ever comes with the NACK command.
  `ISQ_ASSERT_NOW(a_rv_with_nack, clk, rst, out_valid && read_valid,
    command == CMD_NACK, "read_valid without NACK command")
  // Transmit data is zero unless a byte is being sent.
  `ISQ_ASSERT_NOW(a_tx_only_on_tx, clk, rst, out_valid && (command != CMD_TX),
    tx_byte == 8'd0, "tx_byte nonzero outside transmit")
  // A start write moves the phase to address-write pending.
  `ISQ_ASSERT_NEXT(a_start_wr_phase, clk, rst, advance && (in_reg.func == FUNC_WRITE),
    state.phase == PH_ADDR_WR, "start write did not set address phase")
  // A start read moves the phase to address-read pending.
  `ISQ_ASSERT_NEXT(a_start_rd_phase, clk, rst, advance && (in_reg.func == FUNC_READ),
    state.phase == PH_ADDR_RD, "start read did not set address phase")

endmodule

### rtl/isq_step.sv
// Combinational step of the sequencer: one word plus current state in,
// one result plus next state out. Depends on isq_pkg.
module isq_step (
  input  isq_pkg::item_t      item,
  input  isq_pkg::seq_state_t state,
  output isq_pkg::seq_state_t state_next,
  output isq_pkg::result_t    result
);
  import isq_pkg::*;

  always_comb begin
    state_next = state;
    result     = '{command: CMD_NONE, tx_byte: 8'd0, read_data: 8'd0, read_valid: 1'b0};
    unique case (item.func)
      FUNC_WRITE: begin
        state_next.held_addr       = item.target_addr;
        state_next.held_write_byte = item.write_byte;
        state_next.phase           = PH_ADDR_WR;
        result.command             = CMD_START;
      end
      FUNC_READ: begin
        state_next.held_addr = item.target_addr;
        state_next.phase     = PH_ADDR_RD;
        result.command       = CMD_START;
      end
      FUNC_EVENT: begin
        unique case (state.phase)
          PH_ADDR_WR: begin
            result.command   = CMD_TX;
            result.tx_byte   = {state.held_addr, 1'b0};
            state_next.phase = PH_DATA_TX;
          end
          PH_ADDR_RD: begin
            result.command   = CMD_TX;
            result.tx_byte   = {state.held_addr, 1'b1};
            state_next.phase = PH_RX_EN;
          end
          PH_DATA_TX: begin
            if (item.nack_seen) begin
              result.command   = CMD_STOP;
              state_next.phase = PH_FINISH;
            end else begin
              result.command   = CMD_TX;
              result.tx_byte   = state.held_write_byte;
              state_next.phase = PH_STOP;
            end
          end
          PH_RX_EN: begin
            if (item.nack_seen) begin
              result.command   = CMD_STOP;
              state_next.phase = PH_FINISH;
            end else begin
              result.command   = CMD_RCEN;
              state_next.phase = PH_RX;
            end
          end
          PH_RX: begin
            result.command    = CMD_NACK;
            result.read_data  = item.rx_byte;
            result.read_valid = 1'b1;
            state_next.phase  = PH_STOP;
          end
          PH_STOP: begin
            result.command   = CMD_STOP;
            state_next.phase = PH_FINISH;
          end
          PH_FINISH: begin
            result.command   = CMD_DONE;
            state_next.phase = PH_RESET;
          end
          default: begin
            // nothing in progress: report no command, stay idle
            state_next.phase = PH_RESET;
          end
        endcase
      end
      default: begin
        // unused function code: no command, state untouched
      end
    endcase
  end

endmodule

### dv/i2c_master_single_byte_sequencer_test.sv
// Self-checking testbench for the single-byte I2C master sequencer.
// Depends on isq_pkg and the i2c_master_single_byte_sequencer top level only.
module i2c_master_single_byte_sequencer_test;
  timeunit 1ns;
  timeprecision 1ps;

  import isq_pkg::*;

  // func code 3 has no meaning in the block; keep it named for the noise words
  localparam logic [1:0] FUNC_UNUSED = 2'd3;
  localparam int STALL_LIMIT = 2000;  // cycles with no handshake on either side
  localparam int DRAIN_CYCLES = 10;   // drain margin after the last accepted result
  localparam int RANDOM_WORDS = 850;

  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic       in_valid = 1'b0;
  logic       in_ready;
  logic [1:0] func = '0;
  logic [6:0] target_addr = '0;
  logic [7:0] write_byte = '0;
  logic       nack_seen = 1'b0;
  logic [7:0] rx_byte = '0;
  logic       out_valid;
  logic       out_ready = 1'b0;
  logic [2:0] command;
  logic [7:0] tx_byte;
  logic [7:0] read_data;
  logic       read_valid;

  i2c_master_single_byte_sequencer dut (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .func(func),
    .target_addr(target_addr),
    .write_byte(write_byte),
    .nack_seen(nack_seen),
    .rx_byte(rx_byte),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .command(command),
    .tx_byte(tx_byte),
    .read_data(read_data),
    .read_valid(read_valid)
  );

  always #4 clk = ~clk;

  // Words waiting to be driven, and engine commands the block still owes us
  item_t   pending_words[$];
  result_t expected_cmds[$];
  int      total_words = 0;
  int      accepted_words = 0;
  int      mismatch_count = 0;
  int      stall_cycles = 0;
  logic    in_took = 1'b0;

  // Shadow copy of the sequencer state
  phase_t     cur_phase = PH_RESET;
  logic [6:0] latched_addr = '0;
  logic [7:0] latched_wbyte = '0;

  task automatic report_mismatch(input string msg);
    $display("ERROR at %0t ns: %s", $time, msg);
    mismatch_count++;
  endtask

  // Work out the engine command for one accepted word and advance the shadow
  // state. A start word always wins, whatever phase the transaction is in.
  function automatic result_t next_command(input item_t w);
    result_t r;
    r = '0;
    r.command = CMD_NONE;
    if (w.func == FUNC_WRITE) begin
      latched_addr = w.target_addr;
      latched_wbyte = w.write_byte;
      cur_phase = PH_ADDR_WR;
      r.command = CMD_START;
    end else if (w.func == FUNC_READ) begin
      // a read leaves the held write byte alone
      latched_addr = w.target_addr;
      cur_phase = PH_ADDR_RD;
      r.command = CMD_START;
    end else if (w.func == FUNC_EVENT) begin
      case (cur_phase)
        PH_ADDR_WR: begin
          r.command = CMD_TX;
          r.tx_byte = {latched_addr, 1'b0};
          cur_phase = PH_DATA_TX;
        end
        PH_ADDR_RD: begin
          r.command = CMD_TX;
          r.tx_byte = {latched_addr, 1'b1};
          cur_phase = PH_RX_EN;
        end
        PH_DATA_TX: begin
          // address NACKed: give up and go straight to STOP
          if (w.nack_seen) begin
            r.command = CMD_STOP;
            cur_phase = PH_FINISH;
          end else begin
            r.command = CMD_TX;
            r.tx_byte = latched_wbyte;
            cur_phase = PH_STOP;
          end
        end
        PH_RX_EN: begin
          if (w.nack_seen) begin
            r.command = CMD_STOP;
            cur_phase = PH_FINISH;
          end else begin
            r.command = CMD_RCEN;
            cur_phase = PH_RX;
          end
        end
        PH_RX: begin
          r.command = CMD_NACK;
          r.read_data = w.rx_byte;
          r.read_valid = 1'b1;
          cur_phase = PH_STOP;
        end
        PH_STOP: begin
          r.command = CMD_STOP;
          cur_phase = PH_FINISH;
        end
        PH_FINISH: begin
          r.command = CMD_DONE;
          cur_phase = PH_RESET;
        end
        default: begin
          // completion with nothing in flight: answer with no command
          r.command = CMD_NONE;
          cur_phase = PH_RESET;
        end
      endcase
    end
    return r;
  endfunction

  task automatic push_word(input logic [1:0] f, input logic [6:0] a, input logic [7:0] wb,
                           input logic n, input logic [7:0] rb);
    item_t w;
    w.func = f;
    w.target_addr = a;
    w.write_byte = wb;
    w.nack_seen = n;
    w.rx_byte = rb;
    pending_words.push_back(w);
  endtask

  task automatic push_random_event(input logic n);
    push_word(FUNC_EVENT, 7'($urandom), 8'($urandom), n, 8'($urandom));
  endtask

  task automatic fill_stimulus();
    int n_events;
    // Completion with nothing in flight, then the unused function code
    push_word(FUNC_EVENT, 7'h7f, 8'hff, 1'b1, 8'hff);
    push_word(FUNC_UNUSED, 7'h7f, 8'hff, 1'b1, 8'hff);
    // Full write at the field maxima; the acknowledge is ignored on the address phase
    push_word(FUNC_WRITE, 7'h7f, 8'hff, 1'b0, 8'h00);
    push_word(FUNC_EVENT, 7'h00, 8'h00, 1'b1, 8'hff);
    push_word(FUNC_EVENT, 7'h00, 8'h00, 1'b0, 8'hff);
    push_word(FUNC_EVENT, 7'h00, 8'h00, 1'b1, 8'hff);
    push_word(FUNC_EVENT, 7'h00, 8'h00, 1'b1, 8'hff);
    // Full read at the minima, received byte at its maximum
    push_word(FUNC_READ, 7'h00, 8'haa, 1'b0, 8'h00);
    push_word(FUNC_EVENT, 7'h7f, 8'hff, 1'b0, 8'h00);
    push_word(FUNC_EVENT, 7'h7f, 8'hff, 1'b0, 8'h00);
    push_word(FUNC_EVENT, 7'h7f, 8'hff, 1'b1, 8'hff);
    push_word(FUNC_EVENT, 7'h7f, 8'hff, 1'b0, 8'h00);
    push_word(FUNC_EVENT, 7'h7f, 8'hff, 1'b0, 8'h00);
    // Write whose address is NACKed
    push_word(FUNC_WRITE, 7'h55, 8'h00, 1'b0, 8'h00);
    push_word(FUNC_EVENT, 7'h00, 8'h00, 1'b0, 8'h00);
    push_word(FUNC_EVENT, 7'h00, 8'h00, 1'b1, 8'h00);
    push_word(FUNC_EVENT, 7'h00, 8'h00, 1'b0, 8'h00);
    // Read whose address is NACKed, abandoned by a start before finishing
    push_word(FUNC_READ, 7'h7f, 8'h00, 1'b0, 8'h00);
    push_word(FUNC_EVENT, 7'h00, 8'h00, 1'b0, 8'h00);
    push_word(FUNC_EVENT, 7'h00, 8'h00, 1'b1, 8'h00);
    // Start while busy, twice in a row, then a read that keeps the old write byte
    push_word(FUNC_WRITE, 7'h2a, 8'h81, 1'b0, 8'h00);
    push_word(FUNC_READ, 7'h13, 8'h00, 1'b0, 8'h00);
    push_word(FUNC_EVENT, 7'h00, 8'h00, 1'b0, 8'h00);
    push_word(FUNC_EVENT, 7'h00, 8'h00, 1'b0, 8'h00);
    push_word(FUNC_EVENT, 7'h00, 8'h00, 1'b0, 8'h00);

    // Mostly well-formed transactions with random content, some cut short or
    // overrun, and one word in ten pure noise
    while (pending_words.size() < 25 + RANDOM_WORDS) begin
      if ($urandom_range(0, 9) == 0) begin
        push_word(2'($urandom_range(0, 3)), 7'($urandom), 8'($urandom), 1'($urandom),
                  8'($urandom));
      end else begin
        push_word($urandom_range(0, 1) ? FUNC_READ : FUNC_WRITE, 7'($urandom),
                  8'($urandom), 1'($urandom), 8'($urandom));
        n_events = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 6) : 5;
        repeat (n_events) push_random_event($urandom_range(0, 4) == 0);
      end
    end
  endtask

  // Driver: present a new word at the falling edge once the last one has gone.
  // Idle pattern: sender 32 / receiver 83 percent, then swapped, then none.
  always @(negedge clk) begin : drive_words
    item_t w;
    int send_idle_pct;
    int recv_idle_pct;
    if (accepted_words < total_words / 3) begin
      send_idle_pct = 32;
      recv_idle_pct = 83;
    end else if (accepted_words < (2 * total_words) / 3) begin
      send_idle_pct = 83;
      recv_idle_pct = 32;
    end else begin
      send_idle_pct = 0;
      recv_idle_pct = 0;
    end
    if (rst) begin
      in_valid <= 1'b0;
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
      // hold the current word until it is taken
      if (!in_valid || in_took) begin
        if (pending_words.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
          w = pending_words.pop_front();
          in_valid <= 1'b1;
          func <= w.func;
          target_addr <= w.target_addr;
          write_byte <= w.write_byte;
          nack_seen <= w.nack_seen;
          rx_byte <= w.rx_byte;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Monitor: predict on each accepted input word, check each accepted result,
  // and watch for a stalled handshake.
  always @(posedge clk) begin : watch_words
    item_t   w;
    result_t got;
    result_t want;
    in_took <= !rst && in_valid && in_ready;
    if (rst) begin
      stall_cycles = 0;
    end else begin
      if (in_valid && in_ready) begin
        w.func = func;
        w.target_addr = target_addr;
        w.write_byte = write_byte;
        w.nack_seen = nack_seen;
        w.rx_byte = rx_byte;
        expected_cmds.push_back(next_command(w));
        accepted_words++;
      end
      if (out_valid && out_ready) begin
        got.command = cmd_t'(command);
        got.tx_byte = tx_byte;
        got.read_data = read_data;
        got.read_valid = read_valid;
        if (expected_cmds.size() == 0) begin
          report_mismatch($sformatf("unexpected result, command %0d", command));
        end else begin
          want = expected_cmds.pop_front();
          if (got.command != want.command)
            report_mismatch($sformatf("command %0d, expected %0d", got.command, want.command));
          if (got.tx_byte != want.tx_byte)
            report_mismatch($sformatf("tx_byte %02h, expected %02h", got.tx_byte,
                                      want.tx_byte));
          if (got.read_data != want.read_data)
            report_mismatch($sformatf("read_data %02h, expected %02h", got.read_data,
                                      want.read_data));
          if (got.read_valid != want.read_valid)
            report_mismatch($sformatf("read_valid %0b, expected %0b", got.read_valid,
                                      want.read_valid));
        end
      end
      // advance the watchdog only while neither channel moves
      if ((in_valid && in_ready) || (out_valid && out_ready)) begin
        stall_cycles = 0;
      end else begin
        stall_cycles++;
        if (stall_cycles >= STALL_LIMIT) begin
          $display("Testbench completed WITH ERRORS");
          $finish;
        end
      end
    end
  end

  // Sequence the run: fill stimulus, release reset, drain and judge
  initial begin
    fill_stimulus();
    total_words = pending_words.size();
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    while (accepted_words < total_words || expected_cmds.size() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    @(negedge clk);
    if (mismatch_count == 0 && expected_cmds.size() == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
